### design/kruskal_wall_union_find_unit_assert.svh
// Assertion macros for the Kruskal wall union-find unit.
`ifndef KRUSKAL_WALL_UNION_FIND_UNIT_ASSERT_SVH
`define KRUSKAL_WALL_UNION_FIND_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is asserted.
`define KWUF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("kwuf assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define KWUF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("kwuf assertion failed");
`else
`define KWUF_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define KWUF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### design/kwuf_pkg.sv
// Shared types and constants for the Kruskal wall union-find unit.
package kwuf_pkg;

  localparam int unsigned KWUF_MAX_ROOMS = 256;
  localparam int unsigned CFG_W          = 9;
  localparam int unsigned ROOM_W         = 8;
  localparam int unsigned LABEL_OUT_W    = 8;

  localparam logic [CFG_W-1:0] ROOM_COUNT_RST = 9'd256;

  // Request codes
  localparam logic REQ_CLEAR = 1'b0;
  localparam logic REQ_WALL  = 1'b1;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_RDB,
    ST_LB,
    ST_SCAN,
    ST_TAIL,
    ST_DONE
  } state_t;

endpackage

### design/kwuf_if.sv
// Valid/ready channel interfaces for wall requests and wall results.
interface kwuf_in_if;
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic [kwuf_pkg::ROOM_W-1:0]  room_a;
  logic [kwuf_pkg::ROOM_W-1:0]  room_b;

  modport source (output valid, output req_type, output room_a, output room_b,
                  input ready);
  modport sink   (input valid, input req_type, input room_a, input room_b,
                  output ready);
endinterface

interface kwuf_out_if;
  logic                             valid;
  logic                             ready;
  logic                             wall_open;
  logic [kwuf_pkg::LABEL_OUT_W-1:0] set_label;

  modport source (output valid, output wall_open, output set_label, input ready);
  modport sink   (input valid, input wall_open, input set_label, output ready);
endinterface

### design/kwuf_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
module kwuf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### design/kruskal_wall_union_find_unit.sv
// Top level of the Kruskal wall union-find unit: sequencer around the label RAM.
//
//   channel | dir | handshake          | payload
//   --------+-----+--------------------+-------------------------------
//   in_ch   | in  | valid / ready      | req_type, room_a, room_b
//   out_ch  | out | valid / ready      | wall_open, set_label
//   cfg     | in  | cfg_we (no stall)  | cfg_wdata = room_count
//
// A wall whose rooms lie outside the active range goes straight to the result,
// a closed wall after both labels are read, an opened wall after a merge that
// walks every active label through the single RAM read port, one room a cycle.
// A clear, and the clearing pass after reset, rewrite all MAX_ROOMS entries,
// one per cycle; no transaction is taken during that pass.
// The result register frees the input side: a new transaction is taken while
// a result still waits on out_ch.
module kruskal_wall_union_find_unit #(
  parameter int unsigned MAX_ROOMS = kwuf_pkg::KWUF_MAX_ROOMS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  kwuf_in_if.sink                    in_ch,
  kwuf_out_if.source                 out_ch,
  input  logic                       cfg_we,
  input  logic [kwuf_pkg::CFG_W-1:0] cfg_wdata
);

  import kwuf_pkg::*;

  `include "kruskal_wall_union_find_unit_assert.svh"

  localparam int unsigned AW = $clog2(MAX_ROOMS);
  localparam int unsigned CW = (AW + 1 > CFG_W) ? AW + 1 : CFG_W;

  state_t           state_r, state_nxt;
  logic [CW-1:0]    i_r, i_nxt;
  logic             from_item_r, from_item_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [CFG_W-1:0] room_count_r;

  logic [AW-1:0]          b_r, la_r, lo_r, hi_r, wa_r;
  logic                   res_open_r;
  logic [LABEL_OUT_W-1:0] res_label_r;
  logic                   out_open_r;
  logic [LABEL_OUT_W-1:0] out_label_r;

  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_wdata, mem_raddr, rd_data;

  logic [CW-1:0] n_active, cnt_ext, max_ext, a_ext, b_ext, rd_ext, lo_ext;
  logic [AW-1:0] lo_c, hi_c;
  logic          accept, out_free, oob, labels_eq, scan_pend, scan_hit;

  // Active room count, saturated at the RAM depth
  assign cnt_ext  = CW'(room_count_r);
  assign max_ext  = CW'(MAX_ROOMS);
  assign n_active = (cnt_ext > max_ext) ? max_ext : cnt_ext;

  assign a_ext = CW'(in_ch.room_a);
  assign b_ext = CW'(in_ch.room_b);
  assign oob   = (a_ext >= n_active) || (b_ext >= n_active);

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // Label compare and merge order
  assign labels_eq = (rd_data == la_r);
  assign lo_c      = (rd_data < la_r) ? rd_data : la_r;
  assign hi_c      = (rd_data < la_r) ? la_r : rd_data;
  assign rd_ext    = CW'(rd_data);
  assign lo_ext    = CW'(lo_c);

  assign scan_pend = (state_r == ST_TAIL) || (i_r != '0);
  assign scan_hit  = scan_pend && (rd_data == hi_r);

  assign in_ch.ready      = (state_r == ST_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.wall_open = out_open_r;
  assign out_ch.set_label = out_label_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_SWEEP: begin
        if (i_r == CW'(MAX_ROOMS - 1)) begin
          state_nxt = from_item_r ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          priority if (in_ch.req_type == REQ_CLEAR) begin
            state_nxt = ST_SWEEP;
          end else if (oob) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_RDB;
          end
        end
      end
      ST_RDB: state_nxt = ST_LB;
      ST_LB:  state_nxt = labels_eq ? ST_DONE : ST_SCAN;
      ST_SCAN: begin
        if (i_r + CW'(1) == n_active) begin
          state_nxt = ST_TAIL;
        end
      end
      ST_TAIL: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // RAM port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = i_r[AW-1:0];
    mem_wdata = i_r[AW-1:0];
    mem_raddr = i_r[AW-1:0];
    unique case (state_r)
      ST_SWEEP: mem_we = 1'b1;
      ST_IDLE:  mem_raddr = a_ext[AW-1:0];
      ST_RDB:   mem_raddr = b_r;
      ST_SCAN, ST_TAIL: begin
        mem_we    = scan_hit;
        mem_waddr = wa_r;
        mem_wdata = lo_r;
      end
      default: mem_we = 1'b0;
    endcase
  end

  // Counter, sweep origin and result-valid next values
  always_comb begin
    i_nxt         = i_r;
    from_item_nxt = from_item_r;
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_SWEEP: begin
        i_nxt = i_r + CW'(1);
        if (i_r == CW'(MAX_ROOMS - 1)) begin
          from_item_nxt = 1'b0;
        end
      end
      ST_IDLE: begin
        i_nxt = '0;
        if (accept && in_ch.req_type == REQ_CLEAR) begin
          from_item_nxt = 1'b1;
        end
      end
      ST_SCAN: i_nxt = i_r + CW'(1);
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
        end
      end
      default: i_nxt = i_r;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_SWEEP;
      i_r          <= '0;
      from_item_r  <= 1'b0;
      out_valid_r  <= 1'b0;
      room_count_r <= ROOM_COUNT_RST;
    end else begin
      state_r     <= state_nxt;
      i_r         <= i_nxt;
      from_item_r <= from_item_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        room_count_r <= cfg_wdata;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        b_r         <= b_ext[AW-1:0];
        res_open_r  <= 1'b0;
        res_label_r <= '0;
      end
      ST_RDB: la_r <= rd_data;
      ST_LB: begin
        lo_r <= lo_c;
        hi_r <= hi_c;
        if (labels_eq) begin
          res_label_r <= rd_ext[LABEL_OUT_W-1:0];
        end else begin
          res_open_r  <= 1'b1;
          res_label_r <= lo_ext[LABEL_OUT_W-1:0];
        end
      end
      ST_SCAN: wa_r <= i_r[AW-1:0];
      ST_DONE: begin
        if (out_free) begin
          out_open_r  <= res_open_r;
          out_label_r <= res_label_r;
        end
      end
      default: wa_r <= wa_r;
    endcase
  end

  kwuf_ram #(
    .WIDTH (AW),
    .DEPTH (MAX_ROOMS)
  ) u_label_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rd_data)
  );

  // Writes happen only in the clearing pass or the relabel walk
  `KWUF_ASSERT_NOW(a_we_state, clk, rst_n, mem_we, (state_r == ST_SWEEP || state_r == ST_SCAN || state_r == ST_TAIL))
  // A relabel write always stores the surviving label
  `KWUF_ASSERT_NOW(a_we_lo, clk, rst_n, (mem_we && state_r != ST_SWEEP), (mem_wdata == lo_r))
  // The walk never reads past the active rooms
  `KWUF_ASSERT_NOW(a_scan_range, clk, rst_n, (state_r == ST_SCAN), (i_r < n_active))
  // A finished transaction lands in the result register
  `KWUF_ASSERT_NEXT(a_result_load, clk, rst_n, (state_r == ST_DONE && out_free), (out_valid_r && state_r == ST_IDLE))

endmodule

### bench/testbench.sv
// Self-checking testbench for the Kruskal wall union-find unit.
`timescale 1ns / 100ps

module testbench;
  import kwuf_pkg::*;

  localparam int unsigned ROOMS         = KWUF_MAX_ROOMS;
  localparam int unsigned SETTLE_CYCLES = ROOMS + 16;
  localparam int unsigned PHASES        = 10;
  localparam int unsigned PHASE_ITEMS   = 160;
  localparam longint      CYCLE_LIMIT   = 3_000_000;
  localparam int unsigned PLAN_ROWS     = 29;

  typedef struct packed {
    logic                   wall_open;
    logic [LABEL_OUT_W-1:0] set_label;
  } wall_outcome_t;

  typedef struct packed {
    logic              is_cfg;
    logic [CFG_W-1:0]  cfg_val;
    logic              req;
    logic [ROOM_W-1:0] room_a;
    logic [ROOM_W-1:0] room_b;
    logic              typed;
    wall_outcome_t     outcome;
  } probe_row_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  kwuf_in_if  in_ch ();
  kwuf_out_if out_ch ();

  kruskal_wall_union_find_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Predicted label of every room and the room count that the block holds
  logic [ROOM_W-1:0] set_of_room [ROOMS];
  logic [CFG_W-1:0]  room_total;
  wall_outcome_t     pending_outcomes [$];
  int                error_count = 0;
  longint            cycle_count = 0;
  bit                idle_en = 1'b1;
  probe_row_t        probe_plan [PLAN_ROWS];

  // Apply one request to the predicted label store and return its outcome
  function automatic wall_outcome_t carve_wall(input logic req,
                                               input logic [ROOM_W-1:0] a,
                                               input logic [ROOM_W-1:0] b);
    wall_outcome_t res;
    int unsigned   live;
    logic [ROOM_W-1:0] lo;
    logic [ROOM_W-1:0] hi;
    res  = '0;
    live = (room_total > ROOMS) ? ROOMS : room_total;
    if (req == REQ_CLEAR) begin
      for (int i = 0; i < ROOMS; i++) set_of_room[i] = ROOM_W'(i);
      return res;
    end
    if (a >= live || b >= live) return res;
    if (set_of_room[a] == set_of_room[b]) begin
      res.set_label = set_of_room[a];
      return res;
    end
    lo = (set_of_room[a] < set_of_room[b]) ? set_of_room[a] : set_of_room[b];
    hi = (set_of_room[a] < set_of_room[b]) ? set_of_room[b] : set_of_room[a];
    // Relabel only the active rooms of the set with the larger label
    for (int i = 0; i < live; i++)
      if (set_of_room[i] == hi) set_of_room[i] = lo;
    res.wall_open = 1'b1;
    res.set_label = lo;
    return res;
  endfunction

  function automatic probe_row_t wall_row(input int a, input int b);
    probe_row_t row;
    row        = '0;
    row.req    = REQ_WALL;
    row.room_a = ROOM_W'(a);
    row.room_b = ROOM_W'(b);
    return row;
  endfunction

  function automatic probe_row_t wall_typed(input int a, input int b,
                                            input logic open, input int label);
    probe_row_t row;
    row                   = wall_row(a, b);
    row.typed             = 1'b1;
    row.outcome.wall_open = open;
    row.outcome.set_label = LABEL_OUT_W'(label);
    return row;
  endfunction

  function automatic probe_row_t clear_row();
    probe_row_t row;
    row        = '0;
    row.req    = REQ_CLEAR;
    row.room_a = '1;
    row.room_b = '1;
    row.typed  = 1'b1;
    return row;
  endfunction

  function automatic probe_row_t cfg_row(input int value);
    probe_row_t row;
    row         = '0;
    row.is_cfg  = 1'b1;
    row.cfg_val = CFG_W'(value);
    return row;
  endfunction

  // Offer one transaction, then log its predicted outcome once accepted
  task automatic offer_item(input logic req, input logic [ROOM_W-1:0] a,
                            input logic [ROOM_W-1:0] b, input logic typed,
                            input wall_outcome_t typed_res);
    int gap;
    wall_outcome_t guess;
    gap = idle_en ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.req_type <= req;
    in_ch.room_a   <= a;
    in_ch.room_b   <= b;
    do @(posedge clk);
    while (!(in_ch.valid === 1'b1 && in_ch.ready === 1'b1));
    guess = carve_wall(req, a, b);
    if (typed) guess = typed_res;
    pending_outcomes = {pending_outcomes, guess};
  endtask

  // Drop valid, drain all results, let any sweep finish, then write the count
  task automatic program_rooms(input logic [CFG_W-1:0] value);
    in_ch.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we     <= 1'b0;
    room_total  = value;
  endtask

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Take results with random stalls and compare against the oldest prediction
  initial begin
    int stall;
    wall_outcome_t want;
    forever begin
      stall = idle_en ? $urandom_range(0, 9) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk);
      while (!(rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1));
      if (pending_outcomes.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result, expected none, actual open %0d label %0d",
                 $time, out_ch.wall_open, out_ch.set_label);
      end else begin
        want = pending_outcomes.pop_front();
        if (out_ch.wall_open !== want.wall_open) begin
          error_count++;
          $display("%0t: wall_open mismatch, expected %0d actual %0d",
                   $time, want.wall_open, out_ch.wall_open);
        end
        if (out_ch.set_label !== want.set_label) begin
          error_count++;
          $display("%0t: set_label mismatch, expected %0d actual %0d",
                   $time, want.set_label, out_ch.set_label);
        end
      end
    end
  end

  // Reset, directed table, random phases, drain and report
  initial begin
    int unsigned span;
    int unsigned live;
    int unsigned pick;
    logic [ROOM_W-1:0] a;
    logic [ROOM_W-1:0] b;
    logic req;

    in_ch.valid    <= 1'b0;
    in_ch.req_type <= REQ_CLEAR;
    in_ch.room_a   <= '0;
    in_ch.room_b   <= '0;
    cfg_we         <= 1'b0;
    cfg_wdata      <= '0;
    rst_n          <= 1'b0;
    room_total      = ROOM_COUNT_RST;
    void'(carve_wall(REQ_CLEAR, '0, '0));

    probe_plan = '{
      wall_typed(0, 255, 1'b1, 0),    // extremes merge into set 0
      wall_typed(255, 0, 1'b0, 0),    // reversed wall now closed
      wall_typed(5, 5, 1'b0, 5),      // same room on both sides
      wall_row(7, 200),
      wall_row(200, 3),
      wall_row(7, 3),
      clear_row(),
      wall_typed(255, 254, 1'b1, 254),
      wall_row(170, 85),
      wall_row(85, 170),
      wall_row(60, 150),              // room 150 goes inactive next
      cfg_row(100),
      wall_row(20, 60),               // inactive 150 keeps label 60
      wall_typed(100, 20, 1'b0, 0),   // room just past the active range
      cfg_row(256),
      wall_row(150, 60),
      cfg_row(4),
      wall_typed(4, 3, 1'b0, 0),
      wall_typed(3, 255, 1'b0, 0),
      wall_row(3, 0),
      wall_row(2, 1),
      wall_row(1, 3),
      cfg_row(511),                   // count saturates at the room limit
      wall_row(255, 128),
      clear_row(),
      cfg_row(2),
      wall_typed(1, 0, 1'b1, 0),
      wall_typed(0, 1, 1'b0, 0),
      wall_typed(2, 0, 1'b0, 0)
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed table
    foreach (probe_plan[i]) begin
      if (probe_plan[i].is_cfg)
        program_rooms(probe_plan[i].cfg_val);
      else
        offer_item(probe_plan[i].req, probe_plan[i].room_a, probe_plan[i].room_b,
                   probe_plan[i].typed, probe_plan[i].outcome);
    end

    // Random phases: each starts from a cleared maze at a new room count
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: span = 16;
        1: span = 2;
        2: span = 511;
        3: span = 256;
        4: span = 3;
        default: begin
          span = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 256)
                                             : $urandom_range(2, 40);
        end
      endcase
      program_rooms(CFG_W'(span));
      idle_en = (p % 4 != 2);
      live    = (span > ROOMS) ? ROOMS : span;
      offer_item(REQ_CLEAR, ROOM_W'($urandom), ROOM_W'($urandom), 1'b0, '0);
      repeat (PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        req  = REQ_WALL;
        a    = ROOM_W'($urandom_range(0, live - 1));
        b    = ROOM_W'($urandom_range(0, live - 1));
        if (pick < 4) begin
          req = REQ_CLEAR;
          a   = ROOM_W'($urandom);
          b   = ROOM_W'($urandom);
        end else if (pick < 10) begin
          a = ROOM_W'($urandom);
          b = ROOM_W'($urandom);
        end else if (pick < 14) begin
          b = a;
        end
        offer_item(req, a, b, 1'b0, '0);
      end
    end

    // Drain and let the block settle before the verdict
    in_ch.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
